// ===== hdl/brq_pkg.sv =====
`default_nettype none

package brq_pkg;

  // Field widths of the stream payloads
  localparam int TYPE_W      = 2;
  localparam int LEN_W       = 4;
  localparam int DATA_W      = 64;
  localparam int STAT_W      = 3;
  localparam int FILL_W      = 13;
  localparam int BYTES       = DATA_W / 8;
  localparam int LANE_W      = $clog2(BYTES);
  localparam int IN_TDATA_W  = ((LEN_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((STAT_W + DATA_W + FILL_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_LOG2 = 1'b1;
  localparam logic [CFG_W-1:0]     CAP_LOG2_RST = 4'd12;

  typedef enum logic [TYPE_W-1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_PEEK = 2'd2,
    REQ_NOP  = 2'd3
  } req_type_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_UNINIT = 3'd1,
    ST_ZERO   = 3'd2,
    ST_OVER   = 3'd3,
    ST_UNDER  = 3'd4
  } status_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic accept;    // latch the request
    logic check;     // latch the status of the request
    logic wr_en;     // write one byte to the store
    logic rd_en;     // issue one byte read
    logic wr_done;   // advance the write count by the length
    logic rd_done;   // last read data lands, advance read count on dequeue
    logic load_out;  // move the result into the output register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic do_write;  // request is an accepted enqueue
    logic do_read;   // request is an accepted dequeue or peek
    logic last;      // byte index is at the last byte of the request
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/brq_ram.sv =====
`default_nettype none

module brq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== hdl/brq_dp.sv =====
`default_nettype none

module brq_dp #(
  parameter int LOG2_DEPTH = 12,
  parameter int MAX_XFER   = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wen,
  input  wire logic [brq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [brq_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire brq_pkg::req_type_t              in_req_type,
  input  wire logic [brq_pkg::LEN_W-1:0]       in_length,
  input  wire logic [brq_pkg::DATA_W-1:0]      in_write_data,
  input  wire brq_pkg::cmd_t                   cmd,
  output brq_pkg::sts_t                        sts,
  output logic [brq_pkg::STAT_W-1:0]           out_status,
  output logic [brq_pkg::DATA_W-1:0]           out_read_data,
  output logic [brq_pkg::FILL_W-1:0]           out_fill_level
);

  localparam int CNT_W = LOG2_DEPTH + 1;

  // Configuration and counts
  logic                        enable_r;
  logic [brq_pkg::CFG_W-1:0]   cap_log2_r;
  logic [CNT_W-1:0]            wr_cnt_r;
  logic [CNT_W-1:0]            rd_cnt_r;
  logic                        rd_vld_r;

  // Request and result payload
  brq_pkg::req_type_t          type_r;
  logic [brq_pkg::LEN_W-1:0]   len_r;
  logic [brq_pkg::DATA_W-1:0]  wdata_r;
  logic [brq_pkg::LEN_W-1:0]   idx_r;
  logic [brq_pkg::LANE_W-1:0]  rd_lane_r;
  logic [brq_pkg::DATA_W-1:0]  rdata_r;
  brq_pkg::status_t            status_r;
  logic [brq_pkg::STAT_W-1:0]  out_status_r;
  logic [brq_pkg::DATA_W-1:0]  out_rdata_r;
  logic [brq_pkg::FILL_W-1:0]  out_fill_r;

  logic [brq_pkg::CFG_W-1:0]   lg_eff;
  logic [CNT_W-1:0]            cap;
  logic [CNT_W-1:0]            amask;
  logic [CNT_W-1:0]            used;
  logic [CNT_W-1:0]            free;
  logic [CNT_W-1:0]            len_ext;
  logic                        too_long;
  brq_pkg::status_t            chk_status;
  logic                        do_write;
  logic                        do_read;
  logic [CNT_W-1:0]            base;
  logic [CNT_W-1:0]            addr_full;
  logic [LOG2_DEPTH-1:0]       ram_addr;
  logic [7:0]                  ram_rdata;

  // Capacity in use, clamped to the store size
  always_comb begin
    if (32'(cap_log2_r) > LOG2_DEPTH) begin
      lg_eff = brq_pkg::CFG_W'(LOG2_DEPTH);
    end else begin
      lg_eff = cap_log2_r;
    end
  end

  assign cap      = CNT_W'(1) << lg_eff;
  assign amask    = cap - CNT_W'(1);
  assign used     = wr_cnt_r - rd_cnt_r;
  assign free     = cap - used;
  assign len_ext  = CNT_W'(len_r);
  assign too_long = (len_r > brq_pkg::LEN_W'(MAX_XFER));

  // Request check: a no-op passes; else enable, then zero length, then length limit with space or data
  always_comb begin
    chk_status = brq_pkg::ST_OK;
    do_write   = 1'b0;
    do_read    = 1'b0;
    if (type_r == brq_pkg::REQ_NOP) begin
      chk_status = brq_pkg::ST_OK;
    end else if (!enable_r) begin
      chk_status = brq_pkg::ST_UNINIT;
    end else if (len_r == '0) begin
      chk_status = brq_pkg::ST_ZERO;
    end else if (type_r == brq_pkg::REQ_ENQ) begin
      if (too_long || (free < len_ext)) begin
        chk_status = brq_pkg::ST_OVER;
      end else begin
        do_write = 1'b1;
      end
    end else begin
      if (too_long || (used < len_ext)) begin
        chk_status = brq_pkg::ST_UNDER;
      end else begin
        do_read = 1'b1;
      end
    end
  end

  assign sts.do_write = do_write;
  assign sts.do_read  = do_read;
  assign sts.last     = (idx_r == (len_r - brq_pkg::LEN_W'(1)));

  // Byte address: count plus byte index, wrapped at the capacity
  assign base      = cmd.wr_en ? wr_cnt_r : rd_cnt_r;
  assign addr_full = (base + CNT_W'(idx_r)) & amask;
  assign ram_addr  = addr_full[LOG2_DEPTH-1:0];

  brq_ram #(
    .WIDTH (8),
    .DEPTH (1 << LOG2_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .addr  (ram_addr),
    .wdata (wdata_r[7:0]),
    .rdata (ram_rdata)
  );

  // Control state: configuration, counts, read-return flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      cap_log2_r <= brq_pkg::CAP_LOG2_RST;
      wr_cnt_r   <= '0;
      rd_cnt_r   <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (cfg_wen) begin
        case (cfg_index)
          brq_pkg::CFG_ENABLE:   enable_r   <= cfg_wdata[0];
          brq_pkg::CFG_CAP_LOG2: cap_log2_r <= cfg_wdata;
          default:               enable_r   <= enable_r;
        endcase
        wr_cnt_r <= '0;
        rd_cnt_r <= '0;
      end else begin
        if (cmd.wr_done) begin
          wr_cnt_r <= wr_cnt_r + len_ext;
        end
        if (cmd.rd_done && (type_r == brq_pkg::REQ_DEQ)) begin
          rd_cnt_r <= rd_cnt_r + len_ext;
        end
      end
    end
  end

  // Payload: request, byte stepping, read assembly, result register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      type_r  <= in_req_type;
      len_r   <= in_length;
      wdata_r <= in_write_data;
      idx_r   <= '0;
      rdata_r <= '0;
    end
    if (cmd.check) begin
      status_r <= chk_status;
    end
    if (cmd.wr_en) begin
      wdata_r <= wdata_r >> 8;
      idx_r   <= idx_r + brq_pkg::LEN_W'(1);
    end
    if (cmd.rd_en) begin
      idx_r     <= idx_r + brq_pkg::LEN_W'(1);
      rd_lane_r <= idx_r[brq_pkg::LANE_W-1:0];
    end
    if (rd_vld_r) begin
      rdata_r[rd_lane_r*8 +: 8] <= ram_rdata;
    end
    if (cmd.load_out) begin
      out_status_r <= status_r;
      out_rdata_r  <= rdata_r;
      out_fill_r   <= brq_pkg::FILL_W'(used);
    end
  end

  assign out_status     = out_status_r;
  assign out_read_data  = out_rdata_r;
  assign out_fill_level = out_fill_r;

  // The stored byte count never exceeds the capacity in use
  a_fill_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    used <= cap)
    else $error("fill level above capacity");

  // The single store port is never asked to read and write at once
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> !cmd.rd_en)
    else $error("store read and write in one cycle");

endmodule

`default_nettype wire

// ===== hdl/brq_ctrl.sv =====
`default_nettype none

module brq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  input  wire brq_pkg::sts_t  sts,
  output brq_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WRITE,
    S_READ,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t state_r;
  logic   out_tvalid_r;
  logic   out_free;

  assign out_free = !out_tvalid_r || out_tready;

  // Commands decoded from the state
  always_comb begin
    cmd          = '0;
    cmd.accept   = (state_r == S_IDLE) && in_tvalid;
    cmd.check    = (state_r == S_CHECK);
    cmd.wr_en    = (state_r == S_WRITE);
    cmd.wr_done  = (state_r == S_WRITE) && sts.last;
    cmd.rd_en    = (state_r == S_READ);
    cmd.rd_done  = (state_r == S_DRAIN);
    cmd.load_out = (state_r == S_DONE) && out_free;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  // State and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (sts.do_write) begin
            state_r <= S_WRITE;
          end else if (sts.do_read) begin
            state_r <= S_READ;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_WRITE: begin
          if (sts.last) begin
            state_r <= S_DONE;
          end
        end
        S_READ: begin
          if (sts.last) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted request is checked in the next cycle
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_CHECK))
    else $error("accepted request not checked");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_tvalid_r || out_tready))
    else $error("result register overwritten");

  // A result appears only after a request was finished
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_DONE))
    else $error("result without finished request");

endmodule

`default_nettype wire

// ===== hdl/byte_ring_queue_core.sv =====
`default_nettype none

// Channel   Direction  Transfer contents
// in_*      input      tuser: req_type[1:0]; tdata: length[3:0], write_data[67:4]
// out_*     output     tdata: status[2:0], read_data[66:3], fill_level[79:67]
// cfg_*     input      write: index 0 queue_enable, index 1 capacity_log2
//
// Each request is checked, then an enqueue writes and a dequeue or peek reads its
// bytes; the single-port store moves one byte a cycle.
// A new request is taken while the previous result still waits in the output
// register; a stalled output holds the controller in its final state.
// rst_n is synchronous: both counts clear, the queue is disabled and the
// capacity is 2^12 bytes. Store contents are not cleared.

module byte_ring_queue_core #(
  parameter int LOG2_DEPTH = 12,
  parameter int MAX_XFER   = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // request stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [brq_pkg::IN_TDATA_W-1:0]      in_tdata,   // length, write_data
  input  wire logic [brq_pkg::TYPE_W-1:0]          in_tuser,   // req_type
  // result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [brq_pkg::OUT_TDATA_W-1:0]          out_tdata,  // status, read_data, fill_level
  // configuration writes
  input  wire logic                                cfg_wen,
  input  wire logic [brq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [brq_pkg::CFG_W-1:0]           cfg_wdata
);

  brq_pkg::cmd_t               cmd;
  brq_pkg::sts_t               sts;
  logic [brq_pkg::STAT_W-1:0]  out_status;
  logic [brq_pkg::DATA_W-1:0]  out_read_data;
  logic [brq_pkg::FILL_W-1:0]  out_fill_level;

  brq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  brq_dp #(
    .LOG2_DEPTH (LOG2_DEPTH),
    .MAX_XFER   (MAX_XFER)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wen        (cfg_wen),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_req_type    (brq_pkg::req_type_t'(in_tuser)),
    .in_length      (in_tdata[brq_pkg::LEN_W-1:0]),
    .in_write_data  (in_tdata[brq_pkg::LEN_W +: brq_pkg::DATA_W]),
    .cmd            (cmd),
    .sts            (sts),
    .out_status     (out_status),
    .out_read_data  (out_read_data),
    .out_fill_level (out_fill_level)
  );

  // Result packing, status in the low bits
  assign out_tdata = brq_pkg::OUT_TDATA_W'({out_fill_level, out_read_data, out_status});

endmodule

`default_nettype wire
